### rtl/mssw_pkg.sv
// Shared constants, types and codes for the multi-slot software watchdog.
`timescale 1ns / 1ps
`default_nettype none

package mssw_pkg;

    // Number of watchdog channels and the widths that follow from it.
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RANK_W = SLOT_W;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TIME_W = 32;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [TIME_W-1:0] time_t;

    // Operation codes carried in the mode field.
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_REGISTER = 3'd1,
        OP_LOGOUT   = 3'd2,
        OP_RELOAD   = 3'd3,
        OP_CHECK    = 3'd4
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RLD_EV,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Write request into the timeout and last-kick store.
    typedef struct packed {
        logic      timeout_we;
        logic      kick_we;
        slot_idx_t addr;
        time_t     timeout;
        time_t     kick;
    } mem_wr_t;

endpackage

`default_nettype wire

### rtl/multi_slot_software_watchdog.sv
// Top level: sequencer, slot state and result register of the software watchdog.
// Tick, register and logout go through EXEC to RESULT; a valid reload also passes RLD_EV.
// Check walks the slots one per cycle through the shared expiry unit and the store's
// single read port and presents its result once the last slot has been evaluated.
// One item is in flight at a time; the next is taken only after RESULT, which rsp_stall can hold.
// Reset clears the state, time counter, active marks, scan and result, not store or ranks.
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_software_watchdog
    import mssw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [2:0]  slot,
    input  wire logic [31:0] amount,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic             expired_found,
    output logic [2:0]       expired_slot,
    output logic             accepted
);

    state_t state_reg, state_next;
    op_t    op_mode_reg, op_mode_next;
    logic [2:0] op_slot_reg, op_slot_next;
    time_t  op_amount_reg, op_amount_next;
    time_t  now_time_reg, now_time_next;
    logic [SLOTS-1:0] active_reg, active_next;
    rank_t  rank_reg [SLOTS];
    rank_t  rank_next [SLOTS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic   eval_vld_reg, eval_vld_next;
    slot_idx_t eval_idx_reg, eval_idx_next;
    logic   res_found_reg, res_found_next;
    logic [2:0] res_slot_reg, res_slot_next;
    logic   res_acc_reg, res_acc_next;
    rank_t  best_rank_reg, best_rank_next;

    mem_wr_t   mem_wr;
    slot_idx_t rd_addr;
    time_t     rd_timeout;
    time_t     rd_kick;
    logic      expired;
    slot_idx_t op_slot_idx;
    logic      op_slot_ok;
    slot_idx_t rank_sel_idx;
    rank_t     rank_sel;
    logic      scan_issue;
    logic      cmd_accept;

    mssw_store u_store (
        .clk        (clk),
        .wr         (mem_wr),
        .rd_addr    (rd_addr),
        .rd_timeout (rd_timeout),
        .rd_kick    (rd_kick)
    );

    mssw_expiry u_expiry (
        .now_time  (now_time_reg),
        .last_kick (rd_kick),
        .timeout   (rd_timeout),
        .expired   (expired)
    );

    // Handshake and result ports.
    assign cmd_stall     = (state_reg != ST_IDLE);
    assign cmd_accept    = cmd_valid && !cmd_stall;
    assign rsp_valid     = (state_reg == ST_RESULT);
    assign expired_found = res_found_reg;
    assign expired_slot  = res_slot_reg;
    assign accepted      = res_acc_reg;

    // Addressed slot and its range check.
    assign op_slot_idx = SLOT_W'(op_slot_reg);
    assign op_slot_ok  = (32'(op_slot_reg) < SLOTS);

    // One read of the rank flops, shared by the scan and by logout.
    assign rank_sel_idx = (state_reg == ST_SCAN) ? eval_idx_reg : op_slot_idx;
    assign rank_sel     = rank_reg[rank_sel_idx];

    // The scan issues one store read per cycle until every slot has been read.
    assign scan_issue = (cnt_reg < CNT_W'(SLOTS));

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers and slot state that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_time_reg  <= '0;
            active_reg    <= '0;
            cnt_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            res_found_reg <= 1'b0;
            res_slot_reg  <= '0;
            res_acc_reg   <= 1'b0;
        end
        else
        begin
            now_time_reg  <= now_time_next;
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            eval_vld_reg  <= eval_vld_next;
            res_found_reg <= res_found_next;
            res_slot_reg  <= res_slot_next;
            res_acc_reg   <= res_acc_next;
        end
    end

    // Payload registers and ranks, which are read only for active slots.
    always_ff @(posedge clk)
    begin
        op_mode_reg   <= op_mode_next;
        op_slot_reg   <= op_slot_next;
        op_amount_reg <= op_amount_next;
        eval_idx_reg  <= eval_idx_next;
        best_rank_reg <= best_rank_next;
        rank_reg      <= rank_next;
    end

    // Sequencer: next state, datapath updates and store requests.
    always_comb
    begin
        state_next     = state_reg;
        op_mode_next   = op_mode_reg;
        op_slot_next   = op_slot_reg;
        op_amount_next = op_amount_reg;
        now_time_next  = now_time_reg;
        active_next    = active_reg;
        rank_next      = rank_reg;
        cnt_next       = cnt_reg;
        eval_vld_next  = eval_vld_reg;
        eval_idx_next  = eval_idx_reg;
        res_found_next = res_found_reg;
        res_slot_next  = res_slot_reg;
        res_acc_next   = res_acc_reg;
        best_rank_next = best_rank_reg;
        mem_wr         = '0;
        rd_addr        = op_slot_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the item and clear the result fields.
                if (cmd_accept)
                begin
                    op_mode_next   = op_t'(mode);
                    op_slot_next   = slot;
                    op_amount_next = amount;
                    res_found_next = 1'b0;
                    res_slot_next  = '0;
                    res_acc_next   = 1'b0;
                    best_rank_next = '0;
                    cnt_next       = '0;
                    eval_vld_next  = 1'b0;
                    state_next     = (op_t'(mode) == OP_CHECK) ? ST_SCAN : ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESULT;
                unique case (op_mode_reg)
                    OP_TICK:
                    begin
                        now_time_next = now_time_reg + op_amount_reg;
                    end
                    OP_REGISTER:
                    begin
                        // Arm an idle slot as the newest one; older ones age by one rank.
                        if (op_slot_ok && !active_reg[op_slot_idx])
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (active_reg[i])
                                begin
                                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                                end
                            end
                            active_next[op_slot_idx] = 1'b1;
                            rank_next[op_slot_idx]   = '0;
                            mem_wr.timeout_we        = 1'b1;
                            mem_wr.kick_we           = 1'b1;
                            mem_wr.addr              = op_slot_idx;
                            mem_wr.timeout           = op_amount_reg;
                            mem_wr.kick              = now_time_reg;
                            res_acc_next             = 1'b1;
                        end
                    end
                    OP_LOGOUT:
                    begin
                        // Disarm the slot and close the gap behind it in the ranks.
                        if (op_slot_ok && active_reg[op_slot_idx])
                        begin
                            active_next[op_slot_idx] = 1'b0;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (active_reg[i] && (rank_reg[i] > rank_sel))
                                begin
                                    rank_next[i] = rank_reg[i] - RANK_W'(1);
                                end
                            end
                            res_acc_next = 1'b1;
                        end
                    end
                    OP_RELOAD:
                    begin
                        // The store read of the slot is issued now and checked next cycle.
                        if (op_slot_ok)
                        begin
                            state_next = ST_RLD_EV;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            ST_RLD_EV:
            begin
                // Restamp only a live slot that has not yet expired.
                if (active_reg[op_slot_idx] && !expired)
                begin
                    mem_wr.kick_we = 1'b1;
                    mem_wr.addr    = op_slot_idx;
                    mem_wr.kick    = now_time_reg;
                    res_acc_next   = 1'b1;
                end
                state_next = ST_RESULT;
            end

            ST_SCAN:
            begin
                // Read the next slot while the one read last cycle is evaluated.
                rd_addr       = cnt_reg[SLOT_W-1:0];
                eval_vld_next = scan_issue;
                eval_idx_next = cnt_reg[SLOT_W-1:0];
                if (scan_issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // Keep the expired slot with the lowest rank seen so far.
                if (eval_vld_reg && active_reg[eval_idx_reg] && expired &&
                    (!res_found_reg || (rank_sel < best_rank_reg)))
                begin
                    res_found_next = 1'b1;
                    res_slot_next  = 3'(eval_idx_reg);
                    best_rank_next = rank_sel;
                end
                if (!scan_issue)
                begin
                    eval_vld_next = 1'b0;
                    state_next    = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/mssw_store.sv
// Per-slot timeout and last-kick memories with one write and one registered read.
`timescale 1ns / 1ps
`default_nettype none

module mssw_store
    import mssw_pkg::*;
(
    input  wire logic      clk,
    input  wire mem_wr_t   wr,
    input  wire slot_idx_t rd_addr,
    output logic [TIME_W-1:0] rd_timeout,
    output logic [TIME_W-1:0] rd_kick
);

    time_t timeout_mem [SLOTS];
    time_t kick_mem [SLOTS];
    time_t rd_timeout_reg;
    time_t rd_kick_reg;

    // Writes at the requested slot; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (wr.timeout_we)
        begin
            timeout_mem[wr.addr] <= wr.timeout;
        end
        if (wr.kick_we)
        begin
            kick_mem[wr.addr] <= wr.kick;
        end
        rd_timeout_reg <= timeout_mem[rd_addr];
        rd_kick_reg    <= kick_mem[rd_addr];
    end

    assign rd_timeout = rd_timeout_reg;
    assign rd_kick    = rd_kick_reg;

endmodule

`default_nettype wire

### rtl/mssw_expiry.sv
// Shared expiry unit: wrapping elapsed time compared against a timeout.
`timescale 1ns / 1ps
`default_nettype none

module mssw_expiry
    import mssw_pkg::*;
(
    input  wire logic [TIME_W-1:0] now_time,
    input  wire logic [TIME_W-1:0] last_kick,
    input  wire logic [TIME_W-1:0] timeout,
    output logic                   expired
);

    time_t elapsed;

    // The subtraction wraps modulo 2^32, so a wrapped counter still works.
    assign elapsed = now_time - last_kick;
    assign expired = (elapsed > timeout);

endmodule

`default_nettype wire
